FILE: src/url_path_guard_and_type_defines.svh
// Assertion macros for the path guard checker.
`ifndef URL_PATH_GUARD_AND_TYPE_DEFINES_SVH
`define URL_PATH_GUARD_AND_TYPE_DEFINES_SVH

// Same-cycle implication, checked at the rising edge of clk.
`define UPG_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("path guard check failed");

// Next-cycle implication, checked at the rising edge of clk.
`define UPG_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("path guard check failed");

`endif

FILE: src/upg_pkg.sv
// Shared types, codes and extension matching for the path guard.
`default_nettype none

package upg_pkg;

  localparam int PATH_LIMIT = 128;
  localparam int MOUNT_W    = 7;
  localparam int COUNT_W    = 8;
  localparam int EXT_DEPTH  = 4;
  localparam int EXT_CHAR_W = 7;
  localparam int EXT_LEN_W  = 3;

  localparam logic [MOUNT_W-1:0] MOUNT_RESET = 7'd4;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_CTRL_LT = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  localparam logic [1:0] VERDICT_DIR    = 2'd0;
  localparam logic [1:0] VERDICT_FILE   = 2'd1;
  localparam logic [1:0] VERDICT_REJECT = 2'd2;

  localparam logic [2:0] CT_OCTET = 3'd0;
  localparam logic [2:0] CT_HTML  = 3'd1;
  localparam logic [2:0] CT_TEXT  = 3'd2;
  localparam logic [2:0] CT_CSS   = 3'd3;
  localparam logic [2:0] CT_JS    = 3'd4;
  localparam logic [2:0] CT_JSON  = 3'd5;

  typedef logic [EXT_DEPTH-1:0][EXT_CHAR_W-1:0] ext_chars_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic [2:0] content_type;
  } res_t;

  function automatic logic [2:0] ext_type(input logic dot, input logic [EXT_LEN_W-1:0] len,
                                          input ext_chars_t c);
    logic htm;
    logic html;
    logic txt;
    logic css;
    logic js;
    logic json;
    logic [2:0] t;
    htm  = (len == 3'd3) && c[0] == 7'h68 && c[1] == 7'h74 && c[2] == 7'h6D;
    html = (len == 3'd4) && c[0] == 7'h68 && c[1] == 7'h74 && c[2] == 7'h6D
           && c[3] == 7'h6C;
    txt  = (len == 3'd3) && c[0] == 7'h74 && c[1] == 7'h78 && c[2] == 7'h74;
    css  = (len == 3'd3) && c[0] == 7'h63 && c[1] == 7'h73 && c[2] == 7'h73;
    js   = (len == 3'd2) && c[0] == 7'h6A && c[1] == 7'h73;
    json = (len == 3'd4) && c[0] == 7'h6A && c[1] == 7'h73 && c[2] == 7'h6F
           && c[3] == 7'h6E;
    t = CT_OCTET;
    if (!dot) begin
      t = CT_OCTET;
    end else if (htm || html) begin
      t = CT_HTML;
    end else if (txt) begin
      t = CT_TEXT;
    end else if (css) begin
      t = CT_CSS;
    end else if (js) begin
      t = CT_JS;
    end else if (json) begin
      t = CT_JSON;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: src/upg_scan.sv
// Running path state and verdict logic for one character word.
`default_nettype none

module upg_scan (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [7:0]                  ch,
  input  wire logic                        last,
  input  wire logic [upg_pkg::MOUNT_W-1:0] mount_length,
  output upg_pkg::res_t                    res
);
  import upg_pkg::*;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_DOT,
    KIND_DOTDOT,
    KIND_OTHER
  } kind_t;

  logic [COUNT_W-1:0]   char_count, char_count_next;
  logic                 bad_seen, bad_seen_next;
  kind_t                component_kind, component_kind_next;
  logic                 dot_seen, dot_seen_next;
  ext_chars_t           ext_chars, ext_chars_next;
  logic [EXT_LEN_W-1:0] ext_length, ext_length_next;

  logic                 first;
  logic                 is_slash;
  logic                 is_dot;
  logic [7:0]           folded;
  logic [EXT_CHAR_W-1:0] stored;
  logic [COUNT_W:0]     total;
  logic                 too_long;

  always_comb begin
    first    = (char_count == '0);
    is_slash = (ch == CH_SLASH);
    is_dot   = (ch == CH_DOT);
    folded   = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? (ch | 8'h20) : ch;
    stored   = folded[7] ? '0 : folded[EXT_CHAR_W-1:0];

    char_count_next     = (char_count == '1) ? char_count : char_count + 1'b1;
    bad_seen_next       = bad_seen;
    component_kind_next = component_kind;
    dot_seen_next       = dot_seen;
    ext_chars_next      = ext_chars;
    ext_length_next     = ext_length;

    if (first) begin
      if (!is_slash) begin
        bad_seen_next = 1'b1;
      end
      component_kind_next = KIND_EMPTY;
    end else begin
      if (char_count == COUNT_W'(1) && is_slash) begin
        bad_seen_next = 1'b1;
      end
      if (ch < CH_CTRL_LT || ch == CH_COLON || ch == CH_BSLASH) begin
        bad_seen_next = 1'b1;
      end
      if (is_slash) begin
        if (component_kind == KIND_DOTDOT) begin
          bad_seen_next = 1'b1;
        end
        component_kind_next = KIND_EMPTY;
      end else if (is_dot) begin
        if (component_kind == KIND_EMPTY) begin
          component_kind_next = KIND_DOT;
        end else if (component_kind == KIND_DOT) begin
          component_kind_next = KIND_DOTDOT;
        end else begin
          component_kind_next = KIND_OTHER;
        end
      end else begin
        component_kind_next = KIND_OTHER;
      end

      if (is_dot) begin
        dot_seen_next   = 1'b1;
        ext_length_next = '0;
        ext_chars_next  = '0;
      end else if (ext_length < EXT_LEN_W'(EXT_DEPTH + 1)) begin
        for (int i = 0; i < EXT_DEPTH; i++) begin
          if (ext_length == EXT_LEN_W'(i)) begin
            ext_chars_next[i] = stored;
          end
        end
        ext_length_next = ext_length + 1'b1;
      end
    end

    total    = {1'b0, char_count_next} + (COUNT_W + 1)'(mount_length);
    too_long = (total >= (COUNT_W + 1)'(PATH_LIMIT));

    if (first) begin
      if (is_slash) begin
        res.verdict      = VERDICT_DIR;
        res.content_type = CT_TEXT;
      end else begin
        res.verdict      = VERDICT_REJECT;
        res.content_type = CT_OCTET;
      end
    end else if (bad_seen_next || component_kind_next == KIND_DOTDOT || too_long) begin
      res.verdict      = VERDICT_REJECT;
      res.content_type = CT_OCTET;
    end else begin
      res.verdict      = VERDICT_FILE;
      res.content_type = ext_type(dot_seen_next, ext_length_next, ext_chars_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && last)) begin
      char_count     <= '0;
      bad_seen       <= 1'b0;
      component_kind <= KIND_EMPTY;
      dot_seen       <= 1'b0;
      ext_chars      <= '0;
      ext_length     <= '0;
    end else if (adv) begin
      char_count     <= char_count_next;
      bad_seen       <= bad_seen_next;
      component_kind <= component_kind_next;
      dot_seen       <= dot_seen_next;
      ext_chars      <= ext_chars_next;
      ext_length     <= ext_length_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/url_path_guard_and_type.sv
// Top level of the request path guard and content type classifier.
//
// Path characters enter on the input channel (in_valid, in_stall, ch, last),
// one character per word; last marks the final character of a path. Exactly
// one result word (verdict, content_type) leaves on the output channel
// (out_valid, out_stall) for each word with last set; other words give none.
// A word is taken at a rising edge with valid high and stall low.
// A result word moves from the input register, which takes its last character,
// to the result register, and a held result can stall it in between.
// Throughput: one character per cycle while in_stall is low, set by the state
// update between the input register and the result register.
// When the receiver stalls, the result word holds; the input register keeps
// taking characters that give no result, and in_stall rises only when a
// final character waits behind a held result.
// mount_length is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (rst, synchronous) empties both registers, clears the path state
// and sets mount_length to 4.
`default_nettype none

module url_path_guard_and_type (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [upg_pkg::MOUNT_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  ch,
  input  wire logic                        last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       verdict,
  output logic [2:0]                       content_type
);
  import upg_pkg::*;

  logic [MOUNT_W-1:0] mount_length;
  logic               s1_valid;
  logic [7:0]         s1_ch;
  logic               s1_last;
  logic               s1_adv;
  res_t               res;

  assign s1_adv   = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_length <= MOUNT_RESET;
    end else if (cfg_wr_en) begin
      mount_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
  end

  upg_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .adv          (s1_adv),
    .ch           (s1_ch),
    .last         (s1_last),
    .mount_length (mount_length),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_last) begin
      verdict      <= res.verdict;
      content_type <= res.content_type;
    end
  end

endmodule

`default_nettype wire

FILE: src/upg_checker.sv
// Port-level checks for the path guard, bound to the top level.
`default_nettype none
`include "url_path_guard_and_type_defines.svh"

module upg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] verdict,
  input wire logic [2:0] content_type
);
  import upg_pkg::*;

  logic [4:0] out_word;
  logic       out_reject;
  logic       out_dir;
  logic       verdict_known;

  assign out_word      = {verdict, content_type};
  assign out_reject    = out_valid && (verdict == VERDICT_REJECT);
  assign out_dir       = out_valid && (verdict == VERDICT_DIR);
  assign verdict_known = (verdict == VERDICT_DIR) || (verdict == VERDICT_FILE) ||
                         (verdict == VERDICT_REJECT);

  `UPG_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)
  `UPG_ASSERT_NEXT(a_hold_result, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  `UPG_ASSERT_NOW(a_reject_octet, clk, rst, out_reject, content_type == CT_OCTET)
  `UPG_ASSERT_NOW(a_dir_text, clk, rst, out_dir, content_type == CT_TEXT)
  `UPG_ASSERT_NOW(a_verdict_code, clk, rst, out_valid, verdict_known)

endmodule

bind url_path_guard_and_type upg_checker u_upg_checker (.*);

`default_nettype wire

FILE: tb/url_path_guard_and_type_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the path guard: directed and random paths against a shadow classifier.
module url_path_guard_and_type_tb;
  import upg_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int EXT_SAT       = 5;
  localparam int N_EXT_NAMES   = 14;

  typedef enum logic [1:0] {COMP_EMPTY, COMP_DOT, COMP_DOTDOT, COMP_OTHER} comp_kind_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [MOUNT_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           ch = '0;
  logic                 last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           verdict;
  logic [2:0]           content_type;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int fail_count     = 0;

  logic [MOUNT_W-1:0]    mount_len = MOUNT_RESET;
  logic [COUNT_W-1:0]    path_len;
  logic                  path_bad;
  comp_kind_t            comp;
  logic                  ext_dot;
  logic [EXT_CHAR_W-1:0] ext_text [EXT_DEPTH];
  logic [EXT_LEN_W-1:0]  ext_len;
  res_t                  verdict_queue[$];
  res_t                  expected_res;

  string ext_names [N_EXT_NAMES] = '{"htm", "HTML", "html", "txt", "TXT", "css", "CsS", "js",
                                     "JS", "json", "JSON", "jso", "jsonx", ""};

  url_path_guard_and_type dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ch(ch),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict),
    .content_type(content_type)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_path();
    path_len = '0;
    path_bad = 1'b0;
    comp     = COMP_EMPTY;
    ext_dot  = 1'b0;
    ext_len  = '0;
    foreach (ext_text[i]) ext_text[i] = '0;
  endfunction

  function automatic bit ext_is(string s);
    if (ext_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if ({1'b0, ext_text[i]} != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [2:0] ext_content();
    if (!ext_dot) return CT_OCTET;
    if (ext_is("htm") || ext_is("html")) return CT_HTML;
    if (ext_is("txt")) return CT_TEXT;
    if (ext_is("css")) return CT_CSS;
    if (ext_is("js")) return CT_JS;
    if (ext_is("json")) return CT_JSON;
    return CT_OCTET;
  endfunction

  function automatic void classify_char(logic [7:0] c, logic fin);
    logic               first;
    logic [COUNT_W-1:0] prev;
    logic [7:0]         f;
    res_t               r;
    first = (path_len == 0);
    prev  = path_len;
    if (path_len != '1) path_len = path_len + 1'b1;
    if (first) begin
      if (c != CH_SLASH) path_bad = 1'b1;
      comp = COMP_EMPTY;
    end else begin
      if (prev == 1 && c == CH_SLASH) path_bad = 1'b1;
      if (c < CH_CTRL_LT || c == CH_COLON || c == CH_BSLASH) path_bad = 1'b1;
      if (c == CH_SLASH) begin
        if (comp == COMP_DOTDOT) path_bad = 1'b1;
        comp = COMP_EMPTY;
      end else if (c == CH_DOT) begin
        comp = (comp == COMP_EMPTY) ? COMP_DOT : (comp == COMP_DOT) ? COMP_DOTDOT : COMP_OTHER;
      end else begin
        comp = COMP_OTHER;
      end
      if (c == CH_DOT) begin
        ext_dot = 1'b1;
        ext_len = '0;
        foreach (ext_text[i]) ext_text[i] = '0;
      end else if (ext_len < EXT_SAT) begin
        if (ext_len < EXT_DEPTH) begin
          f = c;
          if (f >= CH_UPPER_A && f <= CH_UPPER_Z) f = f + 8'd32;
          if (f[7]) f = '0;
          ext_text[ext_len[1:0]] = f[EXT_CHAR_W-1:0];
        end
        ext_len = ext_len + 1'b1;
      end
    end
    if (fin) begin
      if (first && c == CH_SLASH) begin
        r.verdict      = VERDICT_DIR;
        r.content_type = CT_TEXT;
      end else if (first || path_bad || comp == COMP_DOTDOT ||
                   int'(path_len) + int'(mount_len) >= PATH_LIMIT) begin
        r.verdict      = VERDICT_REJECT;
        r.content_type = CT_OCTET;
      end else begin
        r.verdict      = VERDICT_FILE;
        r.content_type = ext_content();
      end
      verdict_queue.push_back(r);
      clear_path();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          $error("unexpected result word: verdict %0d, content_type %0d",
                 verdict, content_type);
          fail_count++;
        end else begin
          expected_res = verdict_queue.pop_front();
          if (verdict !== expected_res.verdict) begin
            $error("verdict: expected %0d, actual %0d", expected_res.verdict, verdict);
            fail_count++;
          end
          if (content_type !== expected_res.content_type) begin
            $error("content_type: expected %0d, actual %0d",
                   expected_res.content_type, content_type);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) classify_char(ch, last);
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_long(input int n);
    send_word(CH_SLASH, n == 1);
    for (int i = 1; i < n; i++) send_word(8'h61, i == n - 1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mount(input logic [MOUNT_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mount_len = v;
  endtask

  task automatic add_component(ref logic [7:0] p[$]);
    int sel;
    sel = $urandom_range(31);
    if (sel == 0) begin
      p.push_back(CH_DOT);
      p.push_back(CH_DOT);
    end else if (sel == 1) begin
      p.push_back(CH_DOT);
    end else if (sel == 2) begin
      repeat ($urandom_range(90, 130)) p.push_back(8'h61 + 8'($urandom_range(25)));
    end else if (sel != 3) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(7))
          0: p.push_back(8'h80 + 8'($urandom_range(127)));
          1: p.push_back(CH_UPPER_A + 8'($urandom_range(25)));
          2: p.push_back(8'h30 + 8'($urandom_range(9)));
          default: p.push_back(8'h61 + 8'($urandom_range(25)));
        endcase
      end
    end
  endtask

  task automatic send_random_path();
    logic [7:0] p[$];
    int         shape;
    int         n;
    string      s;
    shape = $urandom_range(99);
    if (shape < 12) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        send_word(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(7) == 0));
      end
      return;
    end
    p.push_back(CH_SLASH);
    repeat ($urandom_range(3)) begin
      add_component(p);
      p.push_back(CH_SLASH);
    end
    add_component(p);
    if ($urandom_range(3) != 0) begin
      p.push_back(CH_DOT);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 5)) p.push_back(8'h61 + 8'($urandom_range(25)));
      end else begin
        s = ext_names[$urandom_range(N_EXT_NAMES - 1)];
        for (int i = 0; i < s.len(); i++) p.push_back(s[i]);
      end
    end
    if (shape < 30) begin
      case ($urandom_range(3))
        0: p[0] = 8'($urandom_range(255));
        1: p.insert($urandom_range(1, p.size()), 8'($urandom_range(31)));
        2: p.insert($urandom_range(1, p.size()), $urandom_range(1) ? CH_COLON : CH_BSLASH);
        default: p.insert(1, CH_SLASH);
      endcase
    end
    foreach (p[i]) send_word(p[i], i == p.size() - 1);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [MOUNT_W-1:0] m, input int n);
    int stop;
    write_mount(m);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop = words_sent + n;
    while (words_sent < stop) send_random_path();
  endtask

  task automatic test_special_paths();
    send_text("/");
    send_text("a");
    send_text("x/y");
    send_text("//a");
    send_text("/a:b");
    send_text("/a\\b");
    send_word(CH_SLASH, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(CH_SLASH, 1'b0);
    send_word(8'h1F, 1'b1);
    send_text("/..");
    send_text("/../a");
    send_text("/a/../b");
    send_text("/.../x");
    send_text("/a/./b.txt");
    send_text("/index.HTML");
    send_text("/a.htm");
    send_text("/b.TxT");
    send_text("/c.css");
    send_text("/d.Js");
    send_text("/e.json");
    send_text("/f.jsonx");
    send_text("/g.");
    send_text("/h.d/js");
    send_text("/~ readme");
    send_word(CH_SLASH, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_DOT, 1'b0);
    send_word(8'hEA, 1'b0);
    send_word(8'h73, 1'b1);
  endtask

  task automatic test_length_limit();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    write_mount(7'd0);
    send_long(127);
    send_long(128);
    send_long(300);
    write_mount(7'd127);
    send_long(1);
    send_long(2);
    write_mount(7'd100);
    send_long(27);
    send_long(28);
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, MOUNT_RESET, 80);
    run_random_phase(0, 0, 7'd0, 80);
    run_random_phase(85, 0, 7'd120, 80);
    run_random_phase(85, 0, 7'($urandom_range(127)), 80);
    run_random_phase(0, 85, 7'd0, 70);
    run_random_phase(0, 85, 7'd127, 60);
    run_random_phase(11, 11, 7'($urandom_range(127)), 80);
    run_random_phase(11, 11, MOUNT_RESET, 80);
  endtask

  initial begin
    clear_path();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_special_paths();
    test_length_limit();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
